@@ rtl/core/pst_pkg.sv @@
package pst_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int DIM_W   = 13;
    localparam int REG_W   = 24;
    localparam int NUM_W   = 2 * REG_W;
    localparam int QUO_W   = 33;
    localparam int OUT_W   = 32;
    localparam int LANES   = 3;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
    localparam logic [REG_W-1:0] FOCAL_RST  = REG_W'(128000);
    localparam logic [REG_W-1:0] BASE_RST   = REG_W'(25600);

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_FOCAL_LENGTH = 2'd2,
        REG_BASELINE     = 2'd3
    } pst_reg_t;

    typedef struct packed {
        logic             zd;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } pst_ctrl_t;

endpackage

@@ rtl/core/pst_front.sv @@
module pst_front #(
    parameter int COORD_BITS = pst_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = pst_pkg::FRAC_BITS_DEF,
    parameter int DW         = COORD_BITS + 1
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [COORD_BITS-1:0]                      lx,
    input  logic [COORD_BITS-1:0]                      rx,
    input  logic [COORD_BITS-1:0]                      ry,
    input  logic [pst_pkg::DIM_W-1:0]                  img_w,
    input  logic [pst_pkg::DIM_W-1:0]                  img_h,
    input  logic [pst_pkg::REG_W-1:0]                  focal,
    input  logic [pst_pkg::REG_W-1:0]                  base,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output pst_pkg::pst_ctrl_t                         out_ctrl,
    output logic [pst_pkg::LANES-1:0][pst_pkg::NUM_W-1:0] out_num,
    output logic [pst_pkg::LANES-1:0][DW-1:0]          out_den
);

    localparam int AW = (COORD_BITS + 1 > pst_pkg::DIM_W) ? COORD_BITS + 1 : pst_pkg::DIM_W;
    localparam int SW = AW + 2;
    localparam int PW = AW + pst_pkg::REG_W;

    logic [SW-1:0]         nx, ny;
    logic [COORD_BITS:0]   d;
    logic [SW-1:0]         nx_abs, ny_abs;
    logic [COORD_BITS:0]   d_abs;

    logic                  s1_valid_reg, s1_valid_next;
    logic [AW-1:0]         ax_reg, ay_reg;
    logic [COORD_BITS-1:0] ad_reg;
    logic                  sx_reg, sy_reg, sd_reg, zd_reg;
    logic                  s1_ready;

    logic                  s2_valid_reg, s2_valid_next;
    logic [PW-1:0]         px, py;
    logic [pst_pkg::NUM_W-1:0] pf;
    pst_pkg::pst_ctrl_t    ctrl_reg;
    logic [pst_pkg::LANES-1:0][pst_pkg::NUM_W-1:0] num_reg;
    logic [pst_pkg::LANES-1:0][DW-1:0] den_reg;
    logic                  s2_ready;

    always_comb
    begin
        nx = SW'(lx) + SW'(rx) - SW'(img_w);
        ny = SW'({ry, 1'b0}) - SW'(img_h);
        d  = (COORD_BITS+1)'(lx) - (COORD_BITS+1)'(rx);
        nx_abs = nx[SW-1] ? (SW'(0) - nx) : nx;
        ny_abs = ny[SW-1] ? (SW'(0) - ny) : ny;
        d_abs  = d[COORD_BITS] ? ((COORD_BITS+1)'(0) - d) : d;
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ax_reg <= nx_abs[AW-1:0];
            ay_reg <= ny_abs[AW-1:0];
            ad_reg <= d_abs[COORD_BITS-1:0];
            sx_reg <= nx[SW-1];
            sy_reg <= ny[SW-1];
            sd_reg <= d[COORD_BITS];
            zd_reg <= (lx == rx);
        end
    end

    always_comb
    begin
        px = PW'(ax_reg) * PW'(base);
        py = PW'(ay_reg) * PW'(base);
        pf = (pst_pkg::NUM_W'(focal) * pst_pkg::NUM_W'(base)) >> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            num_reg[pst_pkg::LANE_X] <= pst_pkg::NUM_W'(px);
            num_reg[pst_pkg::LANE_Y] <= pst_pkg::NUM_W'(py);
            num_reg[pst_pkg::LANE_Z] <= pf;
            den_reg[pst_pkg::LANE_X] <= DW'({ad_reg, 1'b0});
            den_reg[pst_pkg::LANE_Y] <= DW'({ad_reg, 1'b0});
            den_reg[pst_pkg::LANE_Z] <= DW'(ad_reg);
            ctrl_reg.zd  <= zd_reg;
            ctrl_reg.neg <= {sd_reg, sy_reg ^ sd_reg, sx_reg ^ sd_reg};
            ctrl_reg.ovf <= '0;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

endmodule

@@ rtl/core/pst_cell.sv @@
module pst_cell #(
    parameter int DW  = pst_pkg::COORD_BITS_DEF + 1,
    parameter int BIT = 0
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  pst_pkg::pst_ctrl_t                            in_ctrl,
    input  logic [pst_pkg::LANES-1:0][DW-1:0]             in_rem,
    input  logic [pst_pkg::LANES-1:0][pst_pkg::NUM_W-1:0] in_num,
    input  logic [pst_pkg::LANES-1:0][DW-1:0]             in_den,
    input  logic [pst_pkg::LANES-1:0][pst_pkg::QUO_W-1:0] in_q,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output pst_pkg::pst_ctrl_t                            out_ctrl,
    output logic [pst_pkg::LANES-1:0][DW-1:0]             out_rem,
    output logic [pst_pkg::LANES-1:0][pst_pkg::NUM_W-1:0] out_num,
    output logic [pst_pkg::LANES-1:0][DW-1:0]             out_den,
    output logic [pst_pkg::LANES-1:0][pst_pkg::QUO_W-1:0] out_q
);

    logic [pst_pkg::LANES-1:0][DW:0]                t, diff;
    logic [pst_pkg::LANES-1:0]                      ge;
    logic [pst_pkg::LANES-1:0][DW-1:0]              rem_next;
    logic [pst_pkg::LANES-1:0][pst_pkg::QUO_W-1:0]  q_next;

    logic                                           valid_reg, valid_next;
    pst_pkg::pst_ctrl_t                             ctrl_reg;
    logic [pst_pkg::LANES-1:0][DW-1:0]              rem_reg, den_reg;
    logic [pst_pkg::LANES-1:0][pst_pkg::NUM_W-1:0]  num_reg;
    logic [pst_pkg::LANES-1:0][pst_pkg::QUO_W-1:0]  q_reg;

    // one restoring step per lane
    always_comb
    begin
        for (int l = 0; l < pst_pkg::LANES; l++)
        begin
            t[l]        = {in_rem[l], in_num[l][BIT]};
            ge[l]       = (t[l] >= {1'b0, in_den[l]});
            diff[l]     = t[l] - {1'b0, in_den[l]};
            rem_next[l] = ge[l] ? diff[l][DW-1:0] : t[l][DW-1:0];
            q_next[l]      = in_q[l];
            q_next[l][BIT] = ge[l];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ctrl_reg <= in_ctrl;
            rem_reg  <= rem_next;
            num_reg  <= in_num;
            den_reg  <= in_den;
            q_reg    <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_q     = q_reg;

endmodule

@@ rtl/core/parallel_stereo_triangulation.sv @@
// Triangulates one matched stereo point pair per clock, unless stalled, into
// signed Q24.8 world coordinates (X, Y, Z) for a parallel camera pair; results
// are truncated toward zero and saturated, with flags for zero disparity and
// clipping. A word passes through two front stages (centring and multiply), a
// chain of 33 divider cells each resolving one quotient bit for all three
// coordinates, and the output register; back-pressure from the output collapses
// bubbles stage by stage. The user must write registers over the APB port only
// while no word is in flight; the block itself does not enforce this.
module parallel_stereo_triangulation #(
    parameter int COORD_BITS = pst_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = pst_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pst_pkg::ADDR_W-1:0]   paddr,
    input  logic [pst_pkg::DATA_W-1:0]   pwdata,
    output logic [pst_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [COORD_BITS-1:0]        left_x,
    input  logic [COORD_BITS-1:0]        left_y,
    input  logic [COORD_BITS-1:0]        right_x,
    input  logic [COORD_BITS-1:0]        right_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [pst_pkg::OUT_W-1:0] world_x,
    output logic signed [pst_pkg::OUT_W-1:0] world_y,
    output logic signed [pst_pkg::OUT_W-1:0] world_z,
    output logic                         zero_disparity,
    output logic                         saturated
);

    localparam int DW    = COORD_BITS + 1;
    localparam int NW    = pst_pkg::NUM_W;
    localparam int QW    = pst_pkg::QUO_W;
    localparam int HW    = NW - QW;
    localparam int RW    = (HW > DW) ? HW : DW;
    localparam int LN    = pst_pkg::LANES;
    localparam int OW    = pst_pkg::OUT_W;

    logic [pst_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [pst_pkg::REG_W-1:0] focal_reg, base_reg;
    logic                      wr_en;
    pst_pkg::pst_reg_t         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = pst_pkg::pst_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pst_pkg::WIDTH_RST;
            height_reg <= pst_pkg::HEIGHT_RST;
            focal_reg  <= pst_pkg::FOCAL_RST;
            base_reg   <= pst_pkg::BASE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                pst_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[pst_pkg::DIM_W-1:0];
                pst_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[pst_pkg::DIM_W-1:0];
                pst_pkg::REG_FOCAL_LENGTH: focal_reg  <= pwdata[pst_pkg::REG_W-1:0];
                pst_pkg::REG_BASELINE:     base_reg   <= pwdata[pst_pkg::REG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            pst_pkg::REG_IMAGE_WIDTH:  prdata = pst_pkg::DATA_W'(width_reg);
            pst_pkg::REG_IMAGE_HEIGHT: prdata = pst_pkg::DATA_W'(height_reg);
            pst_pkg::REG_FOCAL_LENGTH: prdata = pst_pkg::DATA_W'(focal_reg);
            pst_pkg::REG_BASELINE:     prdata = pst_pkg::DATA_W'(base_reg);
        endcase
    end

    // front end
    logic                           f_valid, f_ready;
    pst_pkg::pst_ctrl_t             f_ctrl;
    logic [LN-1:0][NW-1:0]          f_num;
    logic [LN-1:0][DW-1:0]          f_den;

    pst_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .lx       (left_x),
        .rx       (right_x),
        .ry       (right_y),
        .img_w    (width_reg),
        .img_h    (height_reg),
        .focal    (focal_reg),
        .base     (base_reg),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_ctrl (f_ctrl),
        .out_num  (f_num),
        .out_den  (f_den)
    );

    // divider chain
    logic                  c_valid [QW+1];
    logic                  c_ready [QW+1];
    pst_pkg::pst_ctrl_t    c_ctrl  [QW+1];
    logic [LN-1:0][DW-1:0] c_rem   [QW+1];
    logic [LN-1:0][NW-1:0] c_num   [QW+1];
    logic [LN-1:0][DW-1:0] c_den   [QW+1];
    logic [LN-1:0][QW-1:0] c_q     [QW+1];

    logic [LN-1:0][RW-1:0] hi_ext, den_ext;
    logic [LN-1:0]         head_ovf;
    logic [LN-1:0][DW-1:0] head_rem;
    pst_pkg::pst_ctrl_t    head_ctrl;

    // quotient of 2^33 or more can only saturate
    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            hi_ext[l]   = RW'(f_num[l][NW-1:QW]);
            den_ext[l]  = RW'(f_den[l]);
            head_ovf[l] = (hi_ext[l] >= den_ext[l]);
            head_rem[l] = head_ovf[l] ? DW'(0) : hi_ext[l][DW-1:0];
        end
        head_ctrl     = f_ctrl;
        head_ctrl.ovf = head_ovf;
    end

    assign c_valid[0] = f_valid;
    assign f_ready    = c_ready[0];
    assign c_ctrl[0]  = head_ctrl;
    assign c_rem[0]   = head_rem;
    assign c_num[0]   = f_num;
    assign c_den[0]   = f_den;
    assign c_q[0]     = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        pst_cell #(
            .DW (DW),
            .BIT(QW - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (c_valid[k]),
            .in_ready (c_ready[k]),
            .in_ctrl  (c_ctrl[k]),
            .in_rem   (c_rem[k]),
            .in_num   (c_num[k]),
            .in_den   (c_den[k]),
            .in_q     (c_q[k]),
            .out_valid(c_valid[k+1]),
            .out_ready(c_ready[k+1]),
            .out_ctrl (c_ctrl[k+1]),
            .out_rem  (c_rem[k+1]),
            .out_num  (c_num[k+1]),
            .out_den  (c_den[k+1]),
            .out_q    (c_q[k+1])
        );
    end

    // saturation and output register
    pst_pkg::pst_ctrl_t    t_ctrl;
    logic [LN-1:0][QW-1:0] t_q;
    logic [LN-1:0]         clip;
    logic [LN-1:0][OW-1:0] res;
    logic                  o_valid_reg, o_valid_next;
    logic [LN-1:0][OW-1:0] res_reg;
    logic                  zd_reg, sat_reg;

    assign t_ctrl = c_ctrl[QW];
    assign t_q    = c_q[QW];

    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            if (t_ctrl.neg[l])
            begin
                clip[l] = t_ctrl.ovf[l] || t_q[l][QW-1]
                          || (t_q[l][OW-1] && (t_q[l][OW-2:0] != '0));
                res[l]  = clip[l] ? {1'b1, {(OW-1){1'b0}}} : (OW'(0) - t_q[l][OW-1:0]);
            end
            else
            begin
                clip[l] = t_ctrl.ovf[l] || t_q[l][QW-1] || t_q[l][OW-1];
                res[l]  = clip[l] ? {1'b0, {(OW-1){1'b1}}} : t_q[l][OW-1:0];
            end
        end
    end

    assign c_ready[QW]  = !o_valid_reg || out_ready;
    assign o_valid_next = c_ready[QW] ? c_valid[QW] : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_valid[QW] && c_ready[QW])
        begin
            res_reg <= t_ctrl.zd ? '0 : res;
            zd_reg  <= t_ctrl.zd;
            sat_reg <= !t_ctrl.zd && (clip != '0);
        end
    end

    assign out_valid      = o_valid_reg;
    assign world_x        = res_reg[pst_pkg::LANE_X];
    assign world_y        = res_reg[pst_pkg::LANE_Y];
    assign world_z        = res_reg[pst_pkg::LANE_Z];
    assign zero_disparity = zd_reg;
    assign saturated      = sat_reg;

    a_zero_disp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_disparity |->
            world_x == '0 && world_y == '0 && world_z == '0 && !saturated)
        else $error("zero disparity word carries nonzero data");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            world_x == 32'h7fffffff || world_x == 32'h80000000 ||
            world_y == 32'h7fffffff || world_y == 32'h80000000 ||
            world_z == 32'h7fffffff || world_z == 32'h80000000)
        else $error("saturated flag without a clipped coordinate");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && reg_sel == pst_pkg::REG_FOCAL_LENGTH |=>
            focal_reg == $past(pwdata[pst_pkg::REG_W-1:0]))
        else $error("focal length write lost");

endmodule

@@ tb/parallel_stereo_triangulation_test.sv @@
module parallel_stereo_triangulation_test;

    typedef struct {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic               zd;
        logic               sat;
    } point_t;

    class point_scoreboard;
        point_t pending[$];
        int     errors;
        logic [12:0] img_w;
        logic [12:0] img_h;
        logic [23:0] focal;
        logic [23:0] base;

        function new();
            errors = 0;
            img_w = pst_pkg::WIDTH_RST;
            img_h = pst_pkg::HEIGHT_RST;
            focal = pst_pkg::FOCAL_RST;
            base = pst_pkg::BASE_RST;
        endfunction

        function logic [31:0] clip(bit neg, logic [63:0] mag, inout bit c);
            if (neg)
            begin
                if (mag > 64'h8000_0000)
                begin
                    mag = 64'h8000_0000;
                    c = 1;
                end
                return 32'(0 - mag[31:0]);
            end
            if (mag > 64'h7FFF_FFFF)
            begin
                mag = 64'h7FFF_FFFF;
                c = 1;
            end
            return mag[31:0];
        endfunction

        function logic [31:0] scaled_div(longint num, longint mul, longint den, inout bit c);
            bit          neg;
            logic [63:0] an;
            logic [63:0] ad;
            logic [63:0] mag;
            neg = (num < 0) != (den < 0);
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            mag = (an * mul) / ad;
            if (mag == 0)
                neg = 0;
            return clip(neg, mag, c);
        endfunction

        function void note_point(logic [11:0] lx, logic [11:0] rx, logic [11:0] ry);
            point_t p;
            longint d;
            bit     c;
            c = 0;
            d = longint'(lx) - longint'(rx);
            if (d == 0)
            begin
                p.wx = 0;
                p.wy = 0;
                p.wz = 0;
                p.zd = 1;
                p.sat = 0;
            end
            else
            begin
                p.wx = scaled_div(longint'(lx) + longint'(rx) - longint'(img_w), base, 2 * d, c);
                p.wy = scaled_div(2 * longint'(ry) - longint'(img_h), base, 2 * d, c);
                p.wz = scaled_div(longint'(focal), base, d * 256, c);
                p.zd = 0;
                p.sat = c;
            end
            pending.push_back(p);
        endfunction

        function void check_point(point_t a);
            point_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected word x=%0d y=%0d z=%0d", $time, a.wx, a.wy, a.wz);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.wx !== e.wx)
                $display("%0t world_x expected %0d actual %0d", $time, e.wx, a.wx);
            if (a.wy !== e.wy)
                $display("%0t world_y expected %0d actual %0d", $time, e.wy, a.wy);
            if (a.wz !== e.wz)
                $display("%0t world_z expected %0d actual %0d", $time, e.wz, a.wz);
            if (a.zd !== e.zd)
                $display("%0t zero_disparity expected %0b actual %0b", $time, e.zd, a.zd);
            if (a.sat !== e.sat)
                $display("%0t saturated expected %0b actual %0b", $time, e.sat, a.sat);
            if (a.wx !== e.wx || a.wy !== e.wy || a.wz !== e.wz || a.zd !== e.zd
                || a.sat !== e.sat)
                errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [11:0] left_x;
    logic [11:0] left_y;
    logic [11:0] right_x;
    logic [11:0] right_y;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic        zero_disparity;
    logic        saturated;

    point_scoreboard sb;
    int  send_idle;
    int  recv_idle;
    int  hold_off;

    parallel_stereo_triangulation uut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            point_t a;
            a.wx = world_x;
            a.wy = world_y;
            a.wz = world_z;
            a.zd = zero_disparity;
            a.sat = saturated;
            sb.check_point(a);
        end
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 0;
            hold_off <= hold_off - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(pst_pkg::pst_reg_t r, logic [31:0] v);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 4'(4 * int'(r));
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (r)
            pst_pkg::REG_IMAGE_WIDTH: sb.img_w = v[12:0];
            pst_pkg::REG_IMAGE_HEIGHT: sb.img_h = v[12:0];
            pst_pkg::REG_FOCAL_LENGTH: sb.focal = v[23:0];
            default: sb.base = v[23:0];
        endcase
    endtask

    // valid drops only while idling, so back to back words keep it high
    task automatic send_point(logic [11:0] lx, logic [11:0] ly, logic [11:0] rx,
                              logic [11:0] ry);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        left_x <= lx;
        left_y <= ly;
        right_x <= rx;
        right_y <= ry;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_point(lx, rx, ry);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_points(int n);
        logic [11:0] lx;
        logic [11:0] rx;
        for (int i = 0; i < n; i++)
        begin
            lx = $urandom;
            case ($urandom_range(3))
                0: rx = lx - 12'($urandom_range(1, 64));
                1: rx = lx - 12'($urandom_range(1, 4));
                2: rx = $urandom;
                default: rx = ($urandom_range(9) == 0) ? lx : lx - 12'($urandom_range(200));
            endcase
            send_point(lx, $urandom, rx, $urandom);
        end
    endtask

    task automatic random_setting();
        write_reg(pst_pkg::REG_IMAGE_WIDTH, $urandom);
        write_reg(pst_pkg::REG_IMAGE_HEIGHT, $urandom);
        write_reg(pst_pkg::REG_FOCAL_LENGTH, $urandom);
        write_reg(pst_pkg::REG_BASELINE,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(65535));
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_valid = 0;
        left_x = 0;
        left_y = 0;
        right_x = 0;
        right_y = 0;
        out_ready = 0;
        hold_off = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        send_point(12'd320, 12'd0, 12'd320, 12'd240);
        send_point(12'd330, 12'd5, 12'd320, 12'd240);
        send_point(12'd320, 12'd7, 12'd330, 12'd100);
        send_point(12'd4095, 12'd4095, 12'd0, 12'd4095);
        send_point(12'd0, 12'd0, 12'd4095, 12'd0);
        send_point(12'd1, 12'd0, 12'd0, 12'd4095);
        send_point(12'd0, 12'd0, 12'd1, 12'd0);
        send_point(12'd4095, 12'd0, 12'd4095, 12'd0);
        send_point(12'hAAA, 12'h555, 12'h555, 12'hAAA);
        send_point(12'h555, 12'hAAA, 12'hAAA, 12'h555);
        drain();
        write_reg(pst_pkg::REG_IMAGE_WIDTH, 0);
        write_reg(pst_pkg::REG_IMAGE_HEIGHT, 0);
        write_reg(pst_pkg::REG_FOCAL_LENGTH, 32'hFF_FFFF);
        write_reg(pst_pkg::REG_BASELINE, 32'hFF_FFFF);
        send_point(12'd1, 12'd0, 12'd0, 12'd4095);
        send_point(12'd0, 12'd0, 12'd4095, 12'd4095);
        send_point(12'd4095, 12'd0, 12'd0, 12'd0);
        drain();
        write_reg(pst_pkg::REG_IMAGE_WIDTH, 32'h1FFF);
        write_reg(pst_pkg::REG_IMAGE_HEIGHT, 32'h1FFF);
        write_reg(pst_pkg::REG_FOCAL_LENGTH, 0);
        write_reg(pst_pkg::REG_BASELINE, 0);
        send_point(12'd4095, 12'd0, 12'd0, 12'd4095);
        send_point(12'd2, 12'd0, 12'd3, 12'd0);
        drain();
        write_reg(pst_pkg::REG_IMAGE_WIDTH, 4096);
        write_reg(pst_pkg::REG_IMAGE_HEIGHT, 1);
        write_reg(pst_pkg::REG_FOCAL_LENGTH, 128000);
        write_reg(pst_pkg::REG_BASELINE, 25600);
        send_point(12'd10, 12'd0, 12'd9, 12'd0);
        drain();

        send_idle = 37;
        recv_idle = 88;
        random_points(250);
        drain();
        random_setting();
        send_idle = 88;
        recv_idle = 37;
        random_points(250);
        drain();
        write_reg(pst_pkg::REG_IMAGE_WIDTH, 640);
        write_reg(pst_pkg::REG_IMAGE_HEIGHT, 480);
        write_reg(pst_pkg::REG_FOCAL_LENGTH, 128000);
        write_reg(pst_pkg::REG_BASELINE, 25600);
        send_idle = 0;
        recv_idle = 0;
        hold_off = 300;
        random_points(200);
        drain();
        random_setting();
        random_points(230);
        drain();

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
